// ===== rtl/team_distance_occupation_defines.svh =====
// Assertion macros shared by the team distance occupation RTL.
`ifndef TEAM_DISTANCE_OCCUPATION_DEFINES_SVH
`define TEAM_DISTANCE_OCCUPATION_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define TDO_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("team_distance_occupation assertion failed");
// Condition this cycle implies expression on the next cycle.
`define TDO_ASSERT_NEXT(lbl, cond, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("team_distance_occupation assertion failed");
`else
`define TDO_ASSERT(lbl, prop)
`define TDO_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

// ===== rtl/tdo_pkg.sv =====
// Types and constants for the team distance occupation block.
package tdo_pkg;

   localparam int TEAM_SIZE   = 7;
   localparam int COORD_BITS  = 11;
   localparam int NUM_PLAYERS = 2 * TEAM_SIZE;
   localparam int IDX_BITS    = 4;
   localparam int OCC_BITS    = 17;

   localparam int DELTA_BITS  = COORD_BITS + 1;
   localparam int D2_BITS     = 2 * COORD_BITS + 1;
   // radicand is d2 * 1024, padded to an even width
   localparam int SQRT_SHIFT  = 10;
   localparam int RAD_BITS    = ((D2_BITS + SQRT_SHIFT + 1) / 2) * 2;
   localparam int ROOT_BITS   = RAD_BITS / 2;
   localparam int REM_BITS    = ROOT_BITS + 1;
   localparam int WORK_BITS   = ROOT_BITS + 3;
   localparam int SAT_BITS    = (ROOT_BITS + 2 > OCC_BITS + 1) ? ROOT_BITS + 2 : OCC_BITS + 1;

   localparam int TREE_LEVELS = (TEAM_SIZE > 1) ? $clog2(TEAM_SIZE) : 1;
   localparam int LEAVES      = 1 << TREE_LEVELS;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic [D2_BITS-1:0] dist2_type;
   typedef logic [NUM_PLAYERS-1:0][D2_BITS-1:0] dist2_vec_type;
   typedef logic [RAD_BITS-1:0] rad_type;
   typedef logic [ROOT_BITS-1:0] root_type;
   typedef logic [REM_BITS-1:0] rem_type;

endpackage

// ===== rtl/team_distance_occupation.sv =====
// Team occupation: nearest team A distance minus nearest team B distance per pixel.
//
// Input channel req_*: req_func selects a load (write player req_player_index
// with req_pos_x/req_pos_y; entries 0-6 team A, 7-13 team B) or a query of the
// pixel at req_pos_x/req_pos_y. A load gives no result; a load index past the
// table is dropped. A query gives one rsp_occupation in signed Q.4.
// Loads take effect at once: a query sees every load accepted before it.
// Reading a player entry never loaded gives an undefined result.
// Pipeline: 23 register stages (2 distance stages, 3 min-tree levels,
// 17 square-root stages, 1 output stage).
// Throughput: one transaction per clock while the output is not stalled,
// loads and queries alike, set by the fully pipelined square-root unit.
// Reset clears all valid bits; the player table keeps its contents.
// When rsp_valid is high and rsp_ready low the whole pipeline holds and
// req_ready drops; nothing is lost or repeated.
`include "team_distance_occupation_defines.svh"
module team_distance_occupation
   import tdo_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [IDX_BITS-1:0]        req_player_index,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OCC_BITS-1:0] rsp_occupation
);

   logic                       advance;
   logic                       accept;
   logic                       d2_valid;
   dist2_vec_type              d2_vec;
   logic                       min_valid;
   dist2_type                  min_a;
   dist2_type                  min_b;
   logic                       sqrt_valid;
   root_type                   root_a;
   root_type                   root_b;
   logic [ROOT_BITS:0]         round_a;
   logic [ROOT_BITS:0]         round_b;
   logic signed [SAT_BITS-1:0] diff;
   logic signed [OCC_BITS-1:0] occ_in;
   logic                       rsp_valid_ff;
   logic signed [OCC_BITS-1:0] rsp_occupation_ff;

   localparam logic signed [SAT_BITS-1:0] OCC_MAX_W = SAT_BITS'((1 << (OCC_BITS - 1)) - 1);
   localparam logic signed [SAT_BITS-1:0] OCC_MIN_W = ~OCC_MAX_W;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   tdo_dist u_dist (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .accept       (accept),
      .func         (req_func),
      .player_index (req_player_index),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .d2_valid     (d2_valid),
      .d2_out       (d2_vec)
   );

   tdo_min_tree u_min_tree (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d2_valid),
      .d2_in     (d2_vec),
      .out_valid (min_valid),
      .min_a     (min_a),
      .min_b     (min_b)
   );

   tdo_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (min_valid),
      .min_a     (min_a),
      .min_b     (min_b),
      .out_valid (sqrt_valid),
      .root_a    (root_a),
      .root_b    (root_b)
   );

   // root has 5 fraction bits here; round half up to 4
   always_comb begin
      round_a = (ROOT_BITS + 1)'(root_a) + (ROOT_BITS + 1)'(1);
      round_b = (ROOT_BITS + 1)'(root_b) + (ROOT_BITS + 1)'(1);
      diff    = signed'(SAT_BITS'(round_a[ROOT_BITS:1])) -
                signed'(SAT_BITS'(round_b[ROOT_BITS:1]));
      if (diff > OCC_MAX_W) begin
         occ_in = OCC_MAX_W[OCC_BITS-1:0];
      end else if (diff < OCC_MIN_W) begin
         occ_in = OCC_MIN_W[OCC_BITS-1:0];
      end else begin
         occ_in = diff[OCC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sqrt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_occupation_ff <= occ_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_occupation = rsp_occupation_ff;

   // a stalled output freezes the pipe, so a finished root waits in place
   `TDO_ASSERT_NEXT(a_stall_holds_root, sqrt_valid && !advance, sqrt_valid)
   // a new result only ever comes from a finished root
   `TDO_ASSERT(a_rsp_from_root, $rose(rsp_valid_ff) |-> $past(sqrt_valid))

endmodule

// ===== rtl/tdo_dist.sv =====
// Player table plus coordinate delta and squared distance stages.
`include "team_distance_occupation_defines.svh"
module tdo_dist
   import tdo_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                accept,
   input  logic                func,
   input  logic [IDX_BITS-1:0] player_index,
   input  coord_type           pos_x,
   input  coord_type           pos_y,
   output logic                d2_valid,
   output dist2_vec_type       d2_out
);

   coord_type     table_x_ff [NUM_PLAYERS];
   coord_type     table_y_ff [NUM_PLAYERS];
   delta_type     dx_ff [NUM_PLAYERS];
   delta_type     dy_ff [NUM_PLAYERS];
   delta_type     dx_in [NUM_PLAYERS];
   delta_type     dy_in [NUM_PLAYERS];
   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic          s2_valid_ff;
   dist2_vec_type d2_ff;
   dist2_vec_type d2_in;
   logic          is_query;

   assign is_query    = (func == FUNC_QUERY);
   assign s1_valid_in = accept && is_query;

   // loads land at the accept edge; a query samples the table as it was then
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_PLAYERS; i++) begin
         if (accept && !is_query && (int'(player_index) == i)) begin
            table_x_ff[i] <= pos_x;
            table_y_ff[i] <= pos_y;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_PLAYERS; i++) begin
         dx_in[i] = DELTA_BITS'(table_x_ff[i]) - DELTA_BITS'(pos_x);
         dy_in[i] = DELTA_BITS'(table_y_ff[i]) - DELTA_BITS'(pos_y);
      end
   end

   always_comb begin
      logic signed [2*DELTA_BITS-1:0] sq_x;
      logic signed [2*DELTA_BITS-1:0] sq_y;
      for (int i = 0; i < NUM_PLAYERS; i++) begin
         sq_x     = dx_ff[i] * dx_ff[i];
         sq_y     = dy_ff[i] * dy_ff[i];
         d2_in[i] = D2_BITS'(sq_x[2*COORD_BITS-1:0]) + D2_BITS'(sq_y[2*COORD_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NUM_PLAYERS; i++) begin
            dx_ff[i] <= dx_in[i];
            dy_ff[i] <= dy_in[i];
         end
         d2_ff <= d2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign d2_valid = s2_valid_ff;
   assign d2_out   = d2_ff;

   // a load or an idle cycle never starts a transaction down the pipe
   `TDO_ASSERT_NEXT(a_load_no_item, advance && !s1_valid_in, !s1_valid_ff)

endmodule

// ===== rtl/tdo_min_tree.sv =====
// Registered minimum trees, one per team, over squared distances.
module tdo_min_tree
   import tdo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  dist2_vec_type d2_in,
   output logic          out_valid,
   output dist2_type     min_a,
   output dist2_type     min_b
);

   // heap layout: node 1 is the root, children of k are 2k and 2k+1
   dist2_type                node_ff [2][1:LEAVES-1];
   dist2_type                leaf_c  [2][LEAVES];
   logic [TREE_LEVELS-1:0]   valid_ff;

   function automatic dist2_type min2(input dist2_type a, input dist2_type b);
      return (b < a) ? b : a;
   endfunction

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         for (int j = 0; j < LEAVES; j++) begin
            if (j < TEAM_SIZE) begin
               leaf_c[t][j] = d2_in[t*TEAM_SIZE+j];
            end else begin
               leaf_c[t][j] = '1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int t = 0; t < 2; t++) begin
            for (int k = 1; k < LEAVES; k++) begin
               if (2 * k >= LEAVES) begin
                  node_ff[t][k] <= min2(leaf_c[t][2*k-LEAVES], leaf_c[t][2*k+1-LEAVES]);
               end else begin
                  node_ff[t][k] <= min2(node_ff[t][2*k], node_ff[t][2*k+1]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= TREE_LEVELS'({valid_ff, in_valid});
      end
   end

   assign out_valid = valid_ff[TREE_LEVELS-1];
   assign min_a     = node_ff[0][1];
   assign min_b     = node_ff[1][1];

endmodule

// ===== rtl/tdo_sqrt_pipe.sv =====
// Two-lane pipelined integer square root, one root bit per stage.
`include "team_distance_occupation_defines.svh"
module tdo_sqrt_pipe
   import tdo_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  dist2_type min_a,
   input  dist2_type min_b,
   output logic      out_valid,
   output root_type  root_a,
   output root_type  root_b
);

   rad_type               rad_ff  [2][ROOT_BITS];
   rem_type               rem_ff  [2][ROOT_BITS];
   root_type              root_ff [2][ROOT_BITS];
   rad_type               rad_in  [2][ROOT_BITS];
   rem_type               rem_in  [2][ROOT_BITS];
   root_type              root_in [2][ROOT_BITS];
   rad_type               rad_first [2];
   logic [ROOT_BITS-1:0]  valid_ff;

   assign rad_first[0] = RAD_BITS'(min_a) << SQRT_SHIFT;
   assign rad_first[1] = RAD_BITS'(min_b) << SQRT_SHIFT;

   always_comb begin
      rad_type                rad_src;
      rem_type                rem_src;
      root_type               root_src;
      logic [WORK_BITS-1:0]   work;
      logic [WORK_BITS-1:0]   trial;
      for (int l = 0; l < 2; l++) begin
         for (int s = 0; s < ROOT_BITS; s++) begin
            if (s == 0) begin
               rad_src  = rad_first[l];
               rem_src  = '0;
               root_src = '0;
            end else begin
               rad_src  = rad_ff[l][s-1];
               rem_src  = rem_ff[l][s-1];
               root_src = root_ff[l][s-1];
            end
            work  = {rem_src, rad_src[RAD_BITS-1 -: 2]};
            trial = WORK_BITS'({root_src, 2'b01});
            rad_in[l][s] = rad_src << 2;
            if (work >= trial) begin
               rem_in[l][s]  = REM_BITS'(work - trial);
               root_in[l][s] = {root_src[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in[l][s]  = REM_BITS'(work);
               root_in[l][s] = {root_src[ROOT_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[ROOT_BITS-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign root_a    = root_ff[0][ROOT_BITS-1];
   assign root_b    = root_ff[1][ROOT_BITS-1];

   // a finished integer root leaves a remainder of at most twice the root
   `TDO_ASSERT(a_rem_bound_a,
      out_valid |-> (rem_ff[0][ROOT_BITS-1] <= {root_ff[0][ROOT_BITS-1], 1'b0}))
   `TDO_ASSERT(a_rem_bound_b,
      out_valid |-> (rem_ff[1][ROOT_BITS-1] <= {root_ff[1][ROOT_BITS-1], 1'b0}))

endmodule
